// ----- src/sc20_pkg.sv -----
// Shared definitions for the stream cipher core: state constants, the
// quarter-round index table, control-store encoding and its contents.
// No dependencies.
package sc20_pkg;

  // Default number of rounds; odd values drop the final single round.
  localparam int unsigned ROUNDS_DEFAULT = 20;

  // Widths of the configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_MID_LOW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_MID_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NONCE        = 3'd4;

  // The four constant words at the head of the input state.
  localparam logic [31:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646E, 32'h79622D32, 32'h6B206574
  };

  // Quarter-round word selection, one nibble each for a, b, c and d from
  // the lowest nibble up. Entries 0 to 3 are the column round, 4 to 7 the
  // diagonal round.
  localparam logic [15:0] QR_SEL [8] = '{
    16'hC840, 16'hD951, 16'hEA62, 16'hFB73,
    16'hFA50, 16'hCB61, 16'hD872, 16'hE943
  };

  // Control store geometry.
  localparam int unsigned PC_W = 4;

  // Operation codes of a control word.
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_WAIT   = 3'd1;
  localparam logic [2:0] OP_TEST   = 3'd2;
  localparam logic [2:0] OP_XOR    = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;
  localparam logic [2:0] OP_QR     = 3'd5;
  localparam logic [2:0] OP_ADD    = 3'd6;
  localparam logic [2:0] OP_FINISH = 3'd7;

  // Sequencing conditions: take the jump target when the condition holds.
  localparam logic [2:0] COND_NONE   = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_EMPTY  = 3'd2;
  localparam logic [2:0] COND_NOBLK  = 3'd3;
  localparam logic [2:0] COND_MORE   = 3'd4;

  // Program addresses that are jumped to.
  localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] PC_TEST   = 4'd1;
  localparam logic [PC_W-1:0] PC_GEN    = 4'd4;
  localparam logic [PC_W-1:0] PC_ROUND  = 4'd5;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd14;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic            diag;
    logic [1:0]      step;
    logic [PC_W-1:0] target;
  } ucode_t;

  // The control program. The double round at steps five to twelve loops
  // until the double-round counter reaches its last value.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, diag: 1'b0, step: 2'd0, target: PC_WAIT};
    case (pc)
      4'd0: begin
        w.op = OP_WAIT; w.cond = COND_NONE;
      end
      4'd1: begin
        w.op = OP_TEST; w.cond = COND_EMPTY; w.target = PC_FINISH;
      end
      4'd2: begin
        w.op = OP_TEST; w.cond = COND_NOBLK; w.target = PC_GEN;
      end
      4'd3: begin
        w.op = OP_XOR; w.cond = COND_ALWAYS; w.target = PC_TEST;
      end
      4'd4: begin
        w.op = OP_LOAD; w.cond = COND_NONE;
      end
      4'd5: begin
        w.op = OP_QR; w.cond = COND_NONE; w.step = 2'd0;
      end
      4'd6: begin
        w.op = OP_QR; w.cond = COND_NONE; w.step = 2'd1;
      end
      4'd7: begin
        w.op = OP_QR; w.cond = COND_NONE; w.step = 2'd2;
      end
      4'd8: begin
        w.op = OP_QR; w.cond = COND_NONE; w.step = 2'd3;
      end
      4'd9: begin
        w.op = OP_QR; w.cond = COND_NONE; w.diag = 1'b1; w.step = 2'd0;
      end
      4'd10: begin
        w.op = OP_QR; w.cond = COND_NONE; w.diag = 1'b1; w.step = 2'd1;
      end
      4'd11: begin
        w.op = OP_QR; w.cond = COND_NONE; w.diag = 1'b1; w.step = 2'd2;
      end
      4'd12: begin
        w.op = OP_QR; w.cond = COND_MORE; w.diag = 1'b1; w.step = 2'd3;
        w.target = PC_ROUND;
      end
      4'd13: begin
        w.op = OP_ADD; w.cond = COND_ALWAYS; w.target = PC_TEST;
      end
      4'd14: begin
        w.op = OP_FINISH; w.cond = COND_ALWAYS; w.target = PC_WAIT;
      end
      default: begin
        w.op = OP_NOP; w.cond = COND_ALWAYS; w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

  // Rotation of one quarter-round step: 16, 12, 8 and 7 bits.
  function automatic logic [31:0] qr_rotl(input logic [31:0] v, input logic [1:0] step);
    logic [31:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      2'd3:    r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ----- src/chacha20_stream_cipher_core.sv -----
// Top level of the stream cipher core: control store sequencer, block state
// datapath, keystream buffer and item handling.
// Depends on sc20_pkg.

// The core XORs message data, eight bytes per item, with a keystream made
// from a 256-bit key, a 64-bit nonce and a 64-bit block counter. One
// keystream block of 64 bytes is made when needed: a load step, the double
// rounds of eight steps each (one add, XOR and rotate step of all four
// quarter-rounds in parallel per cycle) and a final add step. An item
// whose bytes lie inside the buffered block is handled by XOR steps alone;
// an item that needs a new block for its first byte, or that crosses into
// a new block part way through, waits for that block to be made. An item
// with a count of zero goes from its test straight to the finish step. A
// full output register holds the last step of an item until the result is
// taken, and a new item is accepted only once the previous result has been
// placed in the output register. Writing any key or nonce register
// restarts the stream at block counter zero.
module chacha20_stream_cipher_core #(
  parameter int unsigned ROUNDS = sc20_pkg::ROUNDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [sc20_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sc20_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input items.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [71:0]                        s_axis_tdata,  // data_in, byte_count, zero pad
  input  logic                               s_axis_tlast,  // end_of_message
  // Result items.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [71:0]                        m_axis_tdata,  // data_out, out_byte_count, zero pad
  output logic                               m_axis_tlast   // out_last
);
  import sc20_pkg::*;

  localparam int unsigned DOUBLE_ROUNDS = ROUNDS / 2;
  localparam int unsigned DR_W = $clog2(DOUBLE_ROUNDS);
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

  // Configuration and stream state.
  logic [63:0]     key_low, key_mid_low, key_mid_high, key_high, nonce_word;
  logic [63:0]     block_counter;
  logic [5:0]      byte_position;
  logic            block_ready;

  // Sequencer.
  logic [PC_W-1:0] pc, pc_next;
  ucode_t          ctl;
  logic            stall;
  logic [DR_W-1:0] dcnt;

  // Block state and keystream buffer.
  logic [31:0]     init_w [16];
  logic [31:0]     x [16];
  logic [31:0]     x_next [16];
  logic [511:0]    ks;

  // Item in progress.
  logic [63:0]     data_rem;
  logic [3:0]      bytes_rem;
  logic [3:0]      bytes_done;
  logic [3:0]      count_eff;
  logic [63:0]     result;
  logic            eom;

  // Output register.
  logic            out_valid;
  logic [63:0]     out_data;
  logic [3:0]      out_count;
  logic            out_last;

  // Quarter-round lanes.
  logic [31:0]     p_new [4];
  logic [31:0]     s_new [4];

  // Byte consumption.
  logic [6:0]      avail;
  logic [3:0]      take;
  logic [6:0]      pos_sum;
  logic [63:0]     byte_mask;
  logic [63:0]     xor_bytes;
  logic [3:0]      in_count;

  logic            in_accept;
  logic            cfg_hit;

  assign ctl   = ucode(pc);
  assign stall = ((ctl.op == OP_WAIT) && !s_axis_tvalid) ||
                 ((ctl.op == OP_FINISH) && out_valid && !m_axis_tready);

  assign s_axis_tready = (ctl.op == OP_WAIT);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_hit       = cfg_we && (cfg_addr <= REG_NONCE);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_count, out_data};
  assign m_axis_tlast  = out_last;

  // Counts above eight are treated as eight.
  assign in_count = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];

  // Next program address.
  always_comb begin
    pc_next = pc + PC_W'(1);
    case (ctl.cond)
      COND_NONE:   pc_next = pc + PC_W'(1);
      COND_ALWAYS: pc_next = ctl.target;
      COND_EMPTY:  if (bytes_rem == 4'd0) pc_next = ctl.target;
      COND_NOBLK:  if (!block_ready) pc_next = ctl.target;
      COND_MORE:   if (dcnt != DR_LAST) pc_next = ctl.target;
      default:     pc_next = PC_WAIT;
    endcase
    if (stall) begin
      pc_next = pc;
    end
  end

  // Input state of a block: constants, key, counter and nonce.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i] = SIGMA[i];
    end
    init_w[4]  = key_low[31:0];       init_w[5]  = key_low[63:32];
    init_w[6]  = key_mid_low[31:0];   init_w[7]  = key_mid_low[63:32];
    init_w[8]  = key_mid_high[31:0];  init_w[9]  = key_mid_high[63:32];
    init_w[10] = key_high[31:0];      init_w[11] = key_high[63:32];
    init_w[12] = block_counter[31:0]; init_w[13] = block_counter[63:32];
    init_w[14] = nonce_word[31:0];    init_w[15] = nonce_word[63:32];
  end

  // Four quarter-round lanes. Even steps update a from b and mix into d;
  // odd steps update c from d and mix into b.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam logic [15:0] SC = QR_SEL[l];
    localparam logic [15:0] SD = QR_SEL[l + 4];
    logic [31:0] wa, wb, wc, wd, p_op, q_op, s_op, sum;

    assign wa   = ctl.diag ? x[SD[3:0]]   : x[SC[3:0]];
    assign wb   = ctl.diag ? x[SD[7:4]]   : x[SC[7:4]];
    assign wc   = ctl.diag ? x[SD[11:8]]  : x[SC[11:8]];
    assign wd   = ctl.diag ? x[SD[15:12]] : x[SC[15:12]];
    assign p_op = ctl.step[0] ? wc : wa;
    assign q_op = ctl.step[0] ? wd : wb;
    assign s_op = ctl.step[0] ? wb : wd;
    assign sum  = p_op + q_op;
    assign p_new[l] = sum;
    assign s_new[l] = qr_rotl(s_op ^ sum, ctl.step);
  end

  // Write-back of the working block state.
  always_comb begin
    x_next = x;
    case (ctl.op)
      OP_LOAD: x_next = init_w;
      OP_QR: begin
        for (int l = 0; l < 4; l++) begin
          if (!ctl.diag && !ctl.step[0]) begin
            x_next[QR_SEL[l][3:0]]   = p_new[l];
            x_next[QR_SEL[l][15:12]] = s_new[l];
          end else if (!ctl.diag) begin
            x_next[QR_SEL[l][11:8]]  = p_new[l];
            x_next[QR_SEL[l][7:4]]   = s_new[l];
          end else if (!ctl.step[0]) begin
            x_next[QR_SEL[l + 4][3:0]]   = p_new[l];
            x_next[QR_SEL[l + 4][15:12]] = s_new[l];
          end else begin
            x_next[QR_SEL[l + 4][11:8]]  = p_new[l];
            x_next[QR_SEL[l + 4][7:4]]   = s_new[l];
          end
        end
      end
      default: x_next = x;
    endcase
  end

  always_ff @(posedge clk) begin
    x <= x_next;
  end

  // Bytes taken this step: the rest of the item or the rest of the block.
  assign avail     = 7'd64 - {1'b0, byte_position};
  assign take      = ({3'd0, bytes_rem} < avail) ? bytes_rem : avail[3:0];
  assign pos_sum   = {1'b0, byte_position} + {3'd0, take};
  assign byte_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {take, 3'b000});
  assign xor_bytes = (data_rem ^ ks[63:0]) & byte_mask;

  // Control state, stream state, keystream buffer and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= PC_WAIT;
      dcnt          <= '0;
      block_counter <= '0;
      byte_position <= '0;
      block_ready   <= 1'b0;
      out_valid     <= 1'b0;
      key_low       <= '0;
      key_mid_low   <= '0;
      key_mid_high  <= '0;
      key_high      <= '0;
      nonce_word    <= '0;
    end else begin
      pc <= pc_next;
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (ctl.op)
        OP_WAIT: begin
          if (in_accept) begin
            data_rem   <= s_axis_tdata[63:0];
            bytes_rem  <= in_count;
            count_eff  <= in_count;
            bytes_done <= 4'd0;
            result     <= '0;
            eom        <= s_axis_tlast;
          end
        end
        OP_XOR: begin
          result        <= result | (xor_bytes << {bytes_done, 3'b000});
          data_rem      <= data_rem >> {take, 3'b000};
          ks            <= ks >> {take, 3'b000};
          bytes_rem     <= bytes_rem - take;
          bytes_done    <= bytes_done + take;
          byte_position <= pos_sum[5:0];
          if (pos_sum[6]) begin
            block_ready <= 1'b0;
          end
        end
        OP_LOAD: dcnt <= '0;
        OP_QR: begin
          if (ctl.cond == COND_MORE) begin
            dcnt <= dcnt + DR_W'(1);
          end
        end
        OP_ADD: begin
          for (int i = 0; i < 16; i++) begin
            ks[32*i +: 32] <= x[i] + init_w[i];
          end
          block_counter <= block_counter + 64'd1;
          byte_position <= '0;
          block_ready   <= 1'b1;
        end
        OP_FINISH: begin
          if (!stall) begin
            out_valid <= 1'b1;
            out_data  <= result;
            out_count <= count_eff;
            out_last  <= eom;
            if (eom) begin
              byte_position <= '0;
              block_ready   <= 1'b0;
            end
          end
        end
        default: ;
      endcase

      // Register writes restart the stream.
      if (cfg_hit) begin
        block_counter <= '0;
        byte_position <= '0;
        block_ready   <= 1'b0;
        case (cfg_addr)
          REG_KEY_LOW:      key_low      <= cfg_data;
          REG_KEY_MID_LOW:  key_mid_low  <= cfg_data;
          REG_KEY_MID_HIGH: key_mid_high <= cfg_data;
          REG_KEY_HIGH:     key_high     <= cfg_data;
          REG_NONCE:        nonce_word   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
